>>> design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, disabled during reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

>>> design/mstp_pkg.sv
// Shared constants for the magnetic stripe track parser: characters, length limits,
// register reset values and indexes, field tags and error codes. No dependencies.
package mstp_pkg;

  // Framing characters
  localparam logic [7:0] CH_PERCENT  = 8'h25;  // '%'
  localparam logic [7:0] CH_FMT_B    = 8'h42;  // 'B'
  localparam logic [7:0] CH_SEMI     = 8'h3B;  // ';'
  localparam logic [7:0] CH_CARET    = 8'h5E;  // '^'
  localparam logic [7:0] CH_EQUAL    = 8'h3D;  // '='
  localparam logic [7:0] CH_QUESTION = 8'h3F;  // '?'
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  // Field length limits
  localparam logic [4:0] PAN_MIN  = 5'd12;
  localparam logic [4:0] PAN_MAX  = 5'd19;
  localparam logic [4:0] NAME_MIN = 5'd2;
  localparam logic [4:0] NAME_MAX = 5'd26;
  localparam logic [4:0] EXP_LEN  = 5'd4;
  localparam logic [4:0] SVC_LEN  = 5'd3;
  localparam logic [4:0] LEN_SAT  = 5'd31;

  // Register reset values
  localparam logic [6:0] MAX_POS_RESET = 7'd78;

  // Field tags
  localparam logic [2:0] TAG_HEADER = 3'd0;
  localparam logic [2:0] TAG_PAN    = 3'd1;
  localparam logic [2:0] TAG_NAME   = 3'd2;
  localparam logic [2:0] TAG_EXP    = 3'd3;
  localparam logic [2:0] TAG_SVC    = 3'd4;
  localparam logic [2:0] TAG_DISC   = 3'd5;
  localparam logic [2:0] TAG_OTHER  = 3'd6;

  // Error codes
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_START     = 4'd1;
  localparam logic [3:0] ERR_PAN_LEN   = 4'd2;
  localparam logic [3:0] ERR_PAN_CHAR  = 4'd3;
  localparam logic [3:0] ERR_NAME_LEN  = 4'd4;
  localparam logic [3:0] ERR_EXP       = 4'd5;
  localparam logic [3:0] ERR_EXP_CHAR  = 4'd6;
  localparam logic [3:0] ERR_SVC       = 4'd7;
  localparam logic [3:0] ERR_SVC_CHAR  = 4'd8;
  localparam logic [3:0] ERR_TOO_LONG  = 4'd9;
  localparam logic [3:0] ERR_TOO_SHORT = 4'd10;

  // Register indexes (byte address = 4 * index)
  localparam logic REG_TRACK_MODE = 1'b0;
  localparam logic REG_MAX_POS    = 1'b1;

endpackage

>>> design/magstripe_track_field_parser.sv
// Magnetic stripe track parser, top level: tags each character with its field.
// Depends on mstp_pkg for characters, tags and error codes.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------------
//  in      | sink      | in_valid / in_ready  | char_in, last_char
//  out     | source    | out_valid / out_ready| field_tag, char_out, field_closed,
//          |           |                      | error_code, record_done, record_ok,
//          |           |                      | end_seen
//  cfg     | APB slave | psel/penable, pready | track_mode @0x0, max_position @0x4
//
// One word per cycle unless out_ready stalls; each accepted word's result is registered.
// The record state updates in one pass of logic between the input and output register.
// in_ready is high whenever the output register is empty or being drained.
// Synchronous reset clears the record state and out_valid and resets the config registers.
module magstripe_track_field_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] field_tag,
  output logic [7:0] char_out,
  output logic       field_closed,
  output logic [3:0] error_code,
  output logic       record_done,
  output logic       record_ok,
  output logic       end_seen,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  // Parser phases
  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_FMT   = 4'd1;
  localparam logic [3:0] PH_PAN   = 4'd2;
  localparam logic [3:0] PH_NAME  = 4'd3;
  localparam logic [3:0] PH_EXP   = 4'd4;
  localparam logic [3:0] PH_SVC   = 4'd5;
  localparam logic [3:0] PH_DISC  = 4'd6;
  localparam logic [3:0] PH_END   = 4'd7;
  localparam logic [3:0] PH_ERR   = 4'd8;

  // Configuration and record state
  logic       track_mode;
  logic [6:0] max_position;
  logic [3:0] phase;
  logic [6:0] position;
  logic [4:0] field_length;
  logic [3:0] sticky_error;
  logic       end_flag;
  logic       past_limit;

  // Per-word results of the phase logic
  logic [3:0] phase_sw;
  logic [4:0] len_sw;
  logic       end_sw;
  logic [2:0] tag_c;
  logic       closed_c;
  logic [3:0] err_c;
  logic [3:0] err_fin;
  logic [3:0] sticky_next;
  logic [3:0] phase_next;

  logic [7:0] sep;
  logic       is_digit;
  logic [4:0] len_inc;
  logic       accept;
  logic       cfg_wr;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      mstp_pkg::REG_TRACK_MODE: prdata = {31'd0, track_mode};
      mstp_pkg::REG_MAX_POS:    prdata = {25'd0, max_position};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track_mode   <= 1'b0;
      max_position <= mstp_pkg::MAX_POS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == mstp_pkg::REG_MAX_POS) begin
        max_position <= pwdata[6:0];
      end else begin
        track_mode <= pwdata[0];
      end
    end
  end

  // Character classes
  assign sep      = track_mode ? mstp_pkg::CH_EQUAL : mstp_pkg::CH_CARET;
  assign is_digit = (char_in >= mstp_pkg::CH_ZERO) && (char_in <= mstp_pkg::CH_NINE);
  assign len_inc  = (field_length == mstp_pkg::LEN_SAT) ? field_length
                                                         : field_length + 5'd1;

  // Field phase logic
  always_comb begin
    phase_sw = phase;
    len_sw   = field_length;
    end_sw   = end_flag;
    tag_c    = mstp_pkg::TAG_OTHER;
    closed_c = 1'b0;
    err_c    = mstp_pkg::ERR_NONE;
    case (phase)
      PH_START: begin
        tag_c = mstp_pkg::TAG_HEADER;
        if (!track_mode) begin
          if (char_in == mstp_pkg::CH_PERCENT) phase_sw = PH_FMT;
          else err_c = mstp_pkg::ERR_START;
        end else if (char_in == mstp_pkg::CH_SEMI) begin
          phase_sw = PH_PAN;
          closed_c = 1'b1;
          len_sw   = 5'd0;
        end else begin
          err_c = mstp_pkg::ERR_START;
        end
      end
      PH_FMT: begin
        tag_c = mstp_pkg::TAG_HEADER;
        if (char_in == mstp_pkg::CH_FMT_B) begin
          phase_sw = PH_PAN;
          closed_c = 1'b1;
          len_sw   = 5'd0;
        end else begin
          err_c = mstp_pkg::ERR_START;
        end
      end
      PH_PAN: begin
        if (is_digit) begin
          tag_c  = mstp_pkg::TAG_PAN;
          len_sw = len_inc;
        end else if (char_in == sep) begin
          if (field_length >= mstp_pkg::PAN_MIN && field_length <= mstp_pkg::PAN_MAX) begin
            closed_c = 1'b1;
            phase_sw = track_mode ? PH_EXP : PH_NAME;
            len_sw   = 5'd0;
          end else begin
            err_c = mstp_pkg::ERR_PAN_LEN;
          end
        end else begin
          tag_c = mstp_pkg::TAG_PAN;
          err_c = mstp_pkg::ERR_PAN_CHAR;
        end
      end
      PH_NAME: begin
        if (char_in != sep) begin
          tag_c  = mstp_pkg::TAG_NAME;
          len_sw = len_inc;
        end else if (field_length >= mstp_pkg::NAME_MIN &&
                     field_length <= mstp_pkg::NAME_MAX) begin
          closed_c = 1'b1;
          phase_sw = PH_EXP;
          len_sw   = 5'd0;
        end else begin
          err_c = mstp_pkg::ERR_NAME_LEN;
        end
      end
      PH_EXP: begin
        if (is_digit) begin
          tag_c  = mstp_pkg::TAG_EXP;
          len_sw = len_inc;
          if (len_inc == mstp_pkg::EXP_LEN) begin
            closed_c = 1'b1;
            phase_sw = PH_SVC;
            len_sw   = 5'd0;
          end
        end else if (char_in == sep) begin
          if (field_length == 5'd0) begin
            closed_c = 1'b1;
            phase_sw = PH_SVC;
          end else begin
            err_c = mstp_pkg::ERR_EXP;
          end
        end else begin
          tag_c = mstp_pkg::TAG_EXP;
          err_c = mstp_pkg::ERR_EXP_CHAR;
        end
      end
      PH_SVC: begin
        if (is_digit) begin
          tag_c  = mstp_pkg::TAG_SVC;
          len_sw = len_inc;
          if (len_inc == mstp_pkg::SVC_LEN) begin
            closed_c = 1'b1;
            phase_sw = PH_DISC;
            len_sw   = 5'd0;
          end
        end else if (char_in == sep) begin
          if (field_length == 5'd0) begin
            closed_c = 1'b1;
            phase_sw = PH_DISC;
          end else begin
            err_c = mstp_pkg::ERR_SVC;
          end
        end else begin
          tag_c = mstp_pkg::TAG_SVC;
          err_c = mstp_pkg::ERR_SVC_CHAR;
        end
      end
      PH_DISC: begin
        if (char_in == mstp_pkg::CH_QUESTION) begin
          closed_c = 1'b1;
          phase_sw = PH_END;
          end_sw   = 1'b1;
        end else begin
          tag_c = mstp_pkg::TAG_DISC;
        end
      end
      default: begin
        tag_c = mstp_pkg::TAG_OTHER;
      end
    endcase
  end

  // Record length checks and sticky error; field errors win
  always_comb begin
    err_fin = err_c;
    if (err_fin == mstp_pkg::ERR_NONE && sticky_error == mstp_pkg::ERR_NONE &&
        (past_limit || position > max_position)) begin
      err_fin = mstp_pkg::ERR_TOO_LONG;
    end
    if (err_fin == mstp_pkg::ERR_NONE && sticky_error == mstp_pkg::ERR_NONE &&
        last_char && position < 7'd2) begin
      err_fin = mstp_pkg::ERR_TOO_SHORT;
    end
    sticky_next = sticky_error;
    phase_next  = phase_sw;
    if (err_fin != mstp_pkg::ERR_NONE && sticky_error == mstp_pkg::ERR_NONE) begin
      sticky_next = err_fin;
      phase_next  = PH_ERR;
    end
  end

  // Record state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      position     <= 7'd0;
      field_length <= 5'd0;
      sticky_error <= mstp_pkg::ERR_NONE;
      end_flag     <= 1'b0;
      past_limit   <= 1'b0;
    end else if (accept) begin
      if (last_char) begin
        phase        <= PH_START;
        position     <= 7'd0;
        field_length <= 5'd0;
        sticky_error <= mstp_pkg::ERR_NONE;
        end_flag     <= 1'b0;
        past_limit   <= 1'b0;
      end else begin
        phase        <= phase_next;
        field_length <= len_sw;
        sticky_error <= sticky_next;
        end_flag     <= end_sw;
        if (position == 7'd127) past_limit <= 1'b1;
        else position <= position + 7'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      field_tag    <= tag_c;
      char_out     <= char_in;
      field_closed <= closed_c && (sticky_next == mstp_pkg::ERR_NONE);
      error_code   <= sticky_next;
      record_done  <= last_char;
      record_ok    <= last_char && (sticky_next == mstp_pkg::ERR_NONE);
      end_seen     <= end_sw;
    end
  end

endmodule

>>> design/mstp_checker.sv
// Port-level checks for the magnetic stripe track parser, with its bind.
// Depends on assert_macros.svh and mstp_pkg.
`include "assert_macros.svh"

module mstp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       field_closed,
  input logic [3:0] error_code,
  input logic       record_done,
  input logic       record_ok,
  input logic       end_seen
);

  // Last delivered word of the current record
  logic       have_prev;
  logic       prev_done;
  logic       prev_end;
  logic [3:0] prev_err;
  logic       out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_fire) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      prev_done <= record_done;
      prev_end  <= end_seen;
      prev_err  <= error_code;
    end
  end

  // A good record ends with no error
  `CHK_SAME(a_ok_clean, clk, rst, out_valid && record_ok,
            record_done && error_code == mstp_pkg::ERR_NONE)

  // No field closes once the record is in error
  `CHK_SAME(a_closed_clean, clk, rst, out_valid && field_closed,
            error_code == mstp_pkg::ERR_NONE)

  // The first error holds until the record ends
  `CHK_SAME(a_err_sticky, clk, rst,
            out_valid && have_prev && !prev_done && prev_err != mstp_pkg::ERR_NONE,
            error_code == prev_err)

  // End sentinel flag holds until the record ends
  `CHK_SAME(a_end_sticky, clk, rst, out_valid && have_prev && !prev_done && prev_end,
            end_seen)

  // A stalled word stays offered
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
            out_valid && $stable(error_code) && $stable(record_done))

endmodule

bind magstripe_track_field_parser mstp_checker u_mstp_checker (.*);
